[hdl/block_permutation_cipher_macros.svh]
// Assertion helpers for the block permutation cipher.
`ifndef BLOCK_PERMUTATION_CIPHER_MACROS_SVH
`define BLOCK_PERMUTATION_CIPHER_MACROS_SVH

// Check a consequence in the same cycle as its cause.
`define BPC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check a consequence in the cycle after its cause.
`define BPC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/bpc_pkg.sv]
`default_nettype none

package bpc_pkg;

  // Field widths
  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 5;
  localparam int KEY_W     = 64;
  localparam int KEY_ENT_W = 4;
  localparam int CFG_IDX_W = 2;

  // Fill and reset characters
  localparam logic [BYTE_W-1:0] PAD_CHAR  = 8'h78;
  localparam logic [BYTE_W-1:0] HOLD_INIT = 8'h26;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE = 2'd0,
    CFG_KEY_MAP    = 2'd1,
    CFG_DECRYPT    = 2'd2
  } cfg_idx_t;

  // Settings the permute unit works from
  typedef struct packed {
    logic [CNT_W-1:0] size;
    logic [KEY_W-1:0] key_map;
    logic             decrypt;
  } perm_cfg_t;

endpackage

`default_nettype wire

[hdl/bpc_in_if.sv]
`default_nettype none

interface bpc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       stream_end;

  modport source (output valid, output data_byte, output stream_end, input ready);
  modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

`default_nettype wire

[hdl/bpc_out_if.sv]
`default_nettype none

interface bpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       block_end;
  logic       message_end;

  modport source (output valid, output out_byte, output block_end, output message_end,
                  input ready);
  modport sink   (input valid, input out_byte, input block_end, input message_end,
                  output ready);
endinterface

`default_nettype wire

[hdl/block_permutation_cipher.sv]
// A flushing byte is registered at acceptance, then its permuted block loads the
// drain bank, and the block's words pass in order through the output register
// to out_ch. One byte per cycle while no flushing byte waits for the drain bank
// to free; a block drains from the bank as the next one fills.
// Reset (rst_n low, synchronous): pipeline empty, fill count zero, hold store
// all '&', block_size 16, key_map 0, encrypt mode.
`default_nettype none

module block_permutation_cipher
  import bpc_pkg::*;
#(
  parameter int MAX_BLOCK = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  bpc_in_if.sink                    in_ch,
  bpc_out_if.source                 out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [KEY_W-1:0]     cfg_data
);

`include "block_permutation_cipher_macros.svh"

  localparam int IDXW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  // Configuration registers
  logic [CNT_W-1:0] cfg_size_r;
  logic [KEY_W-1:0] cfg_key_r;
  logic             cfg_decrypt_r;
  logic [CNT_W-1:0] eff_size;
  perm_cfg_t        perm_cfg;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_size_r    <= CNT_W'(16);
      cfg_key_r     <= '0;
      cfg_decrypt_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_BLOCK_SIZE: cfg_size_r    <= cfg_data[CNT_W-1:0];
        CFG_KEY_MAP:    cfg_key_r     <= cfg_data;
        CFG_DECRYPT:    cfg_decrypt_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Clamp block size to 1..MAX_BLOCK
  always_comb begin
    if (cfg_size_r == '0) begin
      eff_size = CNT_W'(1);
    end else if (cfg_size_r > CNT_W'(MAX_BLOCK)) begin
      eff_size = CNT_W'(MAX_BLOCK);
    end else begin
      eff_size = cfg_size_r;
    end
  end

  assign perm_cfg = '{size: eff_size, key_map: cfg_key_r, decrypt: cfg_decrypt_r};

  // Input register
  logic              s1_valid_r;
  logic [BYTE_W-1:0] s1_byte_r;
  logic              s1_last_r;
  logic              s1_go;
  logic              s1_flush;

  // Block being filled and the encrypt hold store
  logic [IDXW-1:0]   fill_r;
  logic [CNT_W-1:0]  fill_new;
  logic [BYTE_W-1:0] input_block [MAX_BLOCK];
  logic [BYTE_W-1:0] hold_r      [MAX_BLOCK];
  logic [BYTE_W-1:0] padded      [MAX_BLOCK];
  logic [BYTE_W-1:0] blk         [MAX_BLOCK];
  logic [BYTE_W-1:0] hold_upd    [MAX_BLOCK];

  // Drain bank and output register
  logic              bank_valid_r;
  logic [BYTE_W-1:0] bank_data_r [MAX_BLOCK];
  logic [CNT_W-1:0]  bank_size_r;
  logic              bank_last_r;
  logic [IDXW-1:0]   bank_idx_r;
  logic              bank_pop;
  logic              bank_at_end;
  logic              bank_free;
  logic              out_valid_r;
  logic [BYTE_W-1:0] out_byte_r;
  logic              out_bend_r;
  logic              out_mend_r;

  assign fill_new    = CNT_W'(fill_r) + CNT_W'(1);
  assign s1_flush    = (fill_new >= eff_size) || s1_last_r;
  assign bank_pop    = bank_valid_r && (!out_valid_r || out_ch.ready);
  assign bank_at_end = (CNT_W'(bank_idx_r) + CNT_W'(1)) == bank_size_r;
  assign bank_free   = !bank_valid_r || (bank_pop && bank_at_end);
  assign s1_go       = s1_valid_r && (!s1_flush || bank_free);
  assign in_ch.ready = !s1_valid_r || s1_go;

  // Hold the incoming word until it can move on
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_byte_r <= in_ch.data_byte;
      s1_last_r <= in_ch.stream_end;
    end
  end

  // Store the byte and advance the fill count, or restart after a flush
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (s1_go) begin
      fill_r <= s1_flush ? '0 : fill_new[IDXW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      input_block[fill_r] <= s1_byte_r;
    end
  end

  // Build the block as written so far, current byte included, padded with 'x'
  always_comb begin
    for (int i = 0; i < MAX_BLOCK; i++) begin
      if (CNT_W'(i) < CNT_W'(fill_r)) begin
        padded[i] = input_block[i];
      end else if (CNT_W'(i) == CNT_W'(fill_r)) begin
        padded[i] = s1_byte_r;
      end else begin
        padded[i] = PAD_CHAR;
      end
    end
  end

  bpc_permute #(
    .MAX_BLOCK (MAX_BLOCK)
  ) u_permute (
    .cfg      (perm_cfg),
    .padded   (padded),
    .hold     (hold_r),
    .blk      (blk),
    .hold_upd (hold_upd)
  );

  // Update the hold store on an encrypt flush; clear it at message end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCK; i++) hold_r[i] <= HOLD_INIT;
    end else if (s1_go && s1_flush) begin
      if (s1_last_r) begin
        for (int i = 0; i < MAX_BLOCK; i++) hold_r[i] <= HOLD_INIT;
      end else if (!cfg_decrypt_r) begin
        hold_r <= hold_upd;
      end
    end
  end

  // Load the drain bank on a flush, advance it on each popped word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_valid_r <= 1'b0;
      bank_idx_r   <= '0;
    end else if (s1_go && s1_flush) begin
      bank_valid_r <= 1'b1;
      bank_idx_r   <= '0;
    end else if (bank_pop) begin
      if (bank_at_end) begin
        bank_valid_r <= 1'b0;
      end else begin
        bank_idx_r <= bank_idx_r + IDXW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_flush) begin
      bank_data_r <= blk;
      bank_size_r <= eff_size;
      bank_last_r <= s1_last_r;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (bank_pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (bank_pop) begin
      out_byte_r <= bank_data_r[bank_idx_r];
      out_bend_r <= bank_at_end;
      out_mend_r <= bank_at_end && bank_last_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.block_end   = out_bend_r;
  assign out_ch.message_end = out_mend_r;

  // Checks
  `BPC_ASSERT_NOW(a_bank_idx_in_block, bank_valid_r,
    CNT_W'(bank_idx_r) < bank_size_r, "drain index beyond block size")
  `BPC_ASSERT_NEXT(a_flush_loads_bank, s1_go && s1_flush,
    bank_valid_r && bank_idx_r == '0, "flush did not start a drain")
  `BPC_ASSERT_NEXT(a_msg_end_clears_hold, s1_go && s1_flush && s1_last_r,
    hold_r[0] == HOLD_INIT, "hold store not cleared at message end")
  `BPC_ASSERT_NOW(a_msg_end_on_block_end, out_valid_r && out_mend_r,
    out_bend_r, "message end without block end")

endmodule

`default_nettype wire

[hdl/bpc_permute.sv]
`default_nettype none

module bpc_permute
  import bpc_pkg::*;
#(
  parameter int MAX_BLOCK = 16
) (
  input  var perm_cfg_t         cfg,
  input  var logic [BYTE_W-1:0] padded   [MAX_BLOCK],
  input  var logic [BYTE_W-1:0] hold     [MAX_BLOCK],
  output var logic [BYTE_W-1:0] blk      [MAX_BLOCK],
  output var logic [BYTE_W-1:0] hold_upd [MAX_BLOCK]
);

  localparam int IDXW = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;

  // Scatter into the hold store; a later source position wins a shared target
  always_comb begin
    logic [KEY_ENT_W-1:0] k;
    for (int j = 0; j < MAX_BLOCK; j++) begin
      hold_upd[j] = hold[j];
      for (int i = 0; i < MAX_BLOCK; i++) begin
        k = cfg.key_map[KEY_ENT_W*i +: KEY_ENT_W];
        if (CNT_W'(i) < cfg.size && CNT_W'(j) < cfg.size && CNT_W'(k) == CNT_W'(j)) begin
          hold_upd[j] = padded[i];
        end
      end
    end
  end

  // Gather for decrypt, or show the updated hold store for encrypt
  always_comb begin
    logic [KEY_ENT_W-1:0] k;
    for (int i = 0; i < MAX_BLOCK; i++) begin
      k = cfg.key_map[KEY_ENT_W*i +: KEY_ENT_W];
      if (cfg.decrypt) begin
        blk[i] = (CNT_W'(k) < cfg.size) ? padded[k[IDXW-1:0]] : PAD_CHAR;
      end else begin
        blk[i] = hold_upd[i];
      end
    end
  end

endmodule

`default_nettype wire
